// ===== rtl/sds_pkg.sv =====
// Shared types, sizes and helper functions of the source duplicate suppressor.
`timescale 1ns / 1ps
package sds_pkg;

    localparam int MAP_COLS   = 1024;
    localparam int MAP_ROWS   = 1024;
    localparam int MAX_RADIUS = 31;
    localparam int NUM_BANDS  = 4;

    localparam int COL_W   = $clog2(MAP_COLS);
    localparam int ROW_W   = $clog2(MAP_ROWS);
    localparam int WORD_W  = (MAP_COLS < 128) ? MAP_COLS / 2 : 64;
    localparam int WB      = $clog2(WORD_W);
    localparam int WPR_W   = COL_W - WB;
    localparam int MEM_DEPTH = MAP_ROWS * (MAP_COLS / WORD_W);
    localparam int ADDR_W  = ROW_W + WPR_W;

    localparam int CMP_A   = ($clog2(MAP_COLS + 1) > $clog2(MAP_ROWS + 1)) ?
                             $clog2(MAP_COLS + 1) : $clog2(MAP_ROWS + 1);
    localparam int CMP_W   = (CMP_A > 11) ? CMP_A : 11;

    localparam int RAD_MAX_Q8 = MAX_RADIUS * 256;
    localparam int R_W     = (RAD_MAX_Q8 > 8191) ? $clog2(RAD_MAX_Q8 + 1) : 13;
    localparam int HALF_W  = R_W - 7;
    localparam int HALF_MAX = ((1 << R_W) - 1 + 128) >> 8;
    localparam int Q_W     = 2 * R_W - 16;
    localparam int D_W     = 2 * HALF_W + 2;
    localparam int PW_A    = (ROW_W > COL_W) ? ROW_W : COL_W;
    localparam int PW      = ((PW_A > HALF_W) ? PW_A : HALF_W) + 2;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam logic [CFG_IDX_W-1:0] REG_CRIT_RADIUS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SAT_SCALE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BAND_SELECT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT  = 3'd4;

    localparam logic CMD_CLEAR  = 1'b0;
    localparam logic CMD_SOURCE = 1'b1;

    typedef struct packed {
        logic [12:0] crit_radius;
        logic [23:0] sat_scale;
        logic [2:0]  band_select;
        logic [10:0] map_width;
        logic [10:0] map_height;
    } cfg_t;

    typedef struct packed {
        logic        command;
        logic [13:0] x_pos;
        logic [13:0] y_pos;
        logic [31:0] strength;
        logic        saturated;
        logic [15:0] band_radius_a;
        logic [15:0] band_radius_b;
        logic [15:0] band_radius_c;
        logic [15:0] band_radius_d;
    } item_t;

    typedef struct packed {
        logic [13:0] kept_x;
        logic [13:0] kept_y;
        logic [31:0] strength_unused_guard;
    } unused_t;

    typedef struct packed {
        logic [13:0] kept_x;
        logic [13:0] kept_y;
        logic [31:0] kept_strength;
        logic [15:0] kept_index;
    } result_t;

    // One queued job: either a clear or an on-map source with its radius.
    typedef struct packed {
        logic             clear;
        logic [13:0]      x_pos;
        logic [13:0]      y_pos;
        logic [31:0]      strength;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic [R_W-1:0]   radius;
    } job_t;

    function automatic logic [CMP_W-1:0] eff_cols(input logic [10:0] w);
        logic [CMP_W-1:0] v;
        v = CMP_W'(w);
        return (v > CMP_W'(MAP_COLS)) ? CMP_W'(MAP_COLS) : v;
    endfunction

    function automatic logic [CMP_W-1:0] eff_rows(input logic [10:0] h);
        logic [CMP_W-1:0] v;
        v = CMP_W'(h);
        return (v > CMP_W'(MAP_ROWS)) ? CMP_W'(MAP_ROWS) : v;
    endfunction

endpackage

// ===== rtl/sds_front.sv =====
// Front end: takes commands, locates the source pixel and works out its radius.
`timescale 1ns / 1ps
module sds_front (
    input  logic            clk,
    input  logic            rst_n,
    input  sds_pkg::cfg_t   cfg,
    input  logic            accept,
    input  sds_pkg::item_t  item,
    output logic            busy,
    output logic            push,
    output sds_pkg::job_t   job
);
    import sds_pkg::*;

    logic             s1_valid_reg, s1_valid_next;
    logic             s1_keep_reg;
    logic             s1_sat_reg;
    logic [39:0]      s1_prod_reg;
    job_t             s1_job_reg;

    logic [14:0]      xs, ys;
    logic [10:0]      x_p1, y_p1;
    logic             on_map;
    logic [15:0]      bsel;
    logic [15:0]      max_ab, max_cd;
    logic [40:0]      rsum;
    logic [24:0]      rnd;
    logic [R_W-1:0]   rsat;
    job_t             in_job;

    always_comb
    begin
        xs   = {1'b0, item.x_pos} + 15'd8;
        ys   = {1'b0, item.y_pos} + 15'd8;
        x_p1 = xs[14:4];
        y_p1 = ys[14:4];
        on_map = (x_p1 != 11'd0) && (y_p1 != 11'd0)
              && (CMP_W'(x_p1) <= eff_cols(cfg.map_width))
              && (CMP_W'(y_p1) <= eff_rows(cfg.map_height));
        max_ab = (item.band_radius_b > item.band_radius_a) ?
                 item.band_radius_b : item.band_radius_a;
        max_cd = (item.band_radius_d > item.band_radius_c) ?
                 item.band_radius_d : item.band_radius_c;
        case (cfg.band_select)
            3'd1:    bsel = item.band_radius_a;
            3'd2:    bsel = item.band_radius_b;
            3'd3:    bsel = item.band_radius_c;
            3'd4:    bsel = item.band_radius_d;
            default: bsel = (max_cd > max_ab) ? max_cd : max_ab;
        endcase
        in_job.clear    = (item.command == CMD_CLEAR);
        in_job.x_pos    = item.x_pos;
        in_job.y_pos    = item.y_pos;
        in_job.strength = item.strength;
        in_job.col      = COL_W'(x_p1 - 11'd1);
        in_job.row      = ROW_W'(y_p1 - 11'd1);
        in_job.radius   = '0;
    end

    assign s1_valid_next = accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_job_reg  <= in_job;
            s1_keep_reg <= (item.command == CMD_CLEAR) || on_map;
            s1_sat_reg  <= item.saturated;
            s1_prod_reg <= 40'(bsel) * 40'(cfg.sat_scale);
        end
    end

    // Round the scaled band radius to Q.8 and saturate it.
    always_comb
    begin
        rsum = {1'b0, s1_prod_reg} + 41'h8000;
        rnd  = rsum[40:16];
        rsat = (rnd > 25'(RAD_MAX_Q8)) ? R_W'(RAD_MAX_Q8) : R_W'(rnd);
        job  = s1_job_reg;
        job.radius = (s1_sat_reg && (rsat >= R_W'(cfg.crit_radius))) ?
                     rsat : R_W'(cfg.crit_radius);
    end

    assign push = s1_valid_reg && s1_keep_reg;
    assign busy = s1_valid_reg;

endmodule

// ===== rtl/sds_queue.sv =====
// Two-entry queue of jobs between the front end and the map sequencer.
`timescale 1ns / 1ps
module sds_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  sds_pkg::job_t  push_job,
    input  logic           pop,
    output logic           head_valid,
    output sds_pkg::job_t  head,
    output logic           full
);
    import sds_pkg::*;

    job_t        entry_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    assign head       = entry_reg[rd_ptr_reg];
    assign head_valid = (count_reg != 2'd0);
    assign full       = (count_reg == 2'd2);

endmodule

// ===== rtl/sds_back.sv =====
// Map sequencer: holds the seen map, checks each source and marks its disc row by row.
`timescale 1ns / 1ps
module sds_back (
    input  logic             clk,
    input  logic             rst_n,
    input  sds_pkg::cfg_t    cfg,
    input  logic             head_valid,
    input  sds_pkg::job_t    head,
    output logic             pop,
    output logic             init_busy,
    output logic             result_valid,
    output sds_pkg::result_t result
);
    import sds_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CLEAR = 3'd1;
    localparam logic [2:0] S_LOOK  = 3'd2;
    localparam logic [2:0] S_ROW   = 3'd3;
    localparam logic [2:0] S_RD    = 3'd4;
    localparam logic [2:0] S_WR    = 3'd5;

    logic [2:0]               state_reg, state_next;
    logic                     init_reg, init_next;
    logic [ADDR_W-1:0]        clr_addr_reg, clr_addr_next;
    job_t                     job_reg;
    logic [2*R_W-1:0]         rsq_reg;
    logic [HALF_W-1:0]        half_reg;
    logic signed [HALF_W+1:0] dy_reg, dy_next;
    logic [ROW_W-1:0]         jrow_reg, jrow_next;
    logic [COL_W-1:0]         lo_reg, lo_next, hi_reg, hi_next;
    logic [WPR_W-1:0]         widx_reg, widx_next;
    logic [15:0]              kept_reg, kept_next;
    logic                     res_valid_reg, res_valid_next;
    result_t                  res_reg;

    logic [WORD_W-1:0]        mem [MEM_DEPTH];
    logic [WORD_W-1:0]        rdata_reg;
    logic                     mem_we, mem_re;
    logic [ADDR_W-1:0]        mem_addr;
    logic [WORD_W-1:0]        mem_wdata, mask;

    logic [R_W:0]             hsum;
    logic signed [PW-1:0]     jj, lo_s, hi_s, col_s;
    logic [HALF_W-1:0]        dy_abs;
    logic signed [D_W-1:0]    tval;
    logic [HALF_W-1:0]        m;
    logic [CMP_W-1:0]         weff, heff;
    logic                     row_ok;
    logic [COL_W-1:0]         pix;

    always_comb
    begin
        weff   = eff_cols(cfg.map_width);
        heff   = eff_rows(cfg.map_height);
        hsum   = {1'b0, head.radius} + (R_W+1)'(128);
        jj     = PW'($signed({1'b0, job_reg.row})) + PW'(dy_reg);
        dy_abs = (dy_reg < 0) ? HALF_W'(-dy_reg) : HALF_W'(dy_reg);
        tval   = D_W'($signed({1'b0, rsq_reg[2*R_W-1:16]}))
               - D_W'($signed({1'b0, D_W'(dy_abs) * D_W'(dy_abs)}));
        // Widest column offset whose squared distance still fits in this row.
        m = '0;
        for (int k = 1; k <= HALF_MAX; k++)
        begin
            if (tval >= $signed(D_W'(k * k)))
            begin
                m = HALF_W'(k);
            end
        end
        col_s = PW'($signed({1'b0, job_reg.col}));
        lo_s  = col_s - PW'($signed({1'b0, m}));
        hi_s  = col_s + PW'($signed({1'b0, m}));
        if (lo_s < 0)
        begin
            lo_s = '0;
        end
        if (hi_s > PW'($signed({1'b0, weff})) - PW'(1))
        begin
            hi_s = PW'($signed({1'b0, weff})) - PW'(1);
        end
        row_ok = (jj >= 0) && (jj < PW'($signed({1'b0, heff}))) && (tval >= 0);
        for (int b = 0; b < WORD_W; b++)
        begin
            pix     = {widx_reg, WB'(b)};
            mask[b] = (pix >= lo_reg) && (pix <= hi_reg);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        init_next      = init_reg;
        clr_addr_next  = clr_addr_reg;
        dy_next        = dy_reg;
        jrow_next      = jrow_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        widx_next      = widx_reg;
        kept_next      = kept_reg;
        res_valid_next = 1'b0;
        pop            = 1'b0;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_addr       = {jrow_reg, widx_reg};
        mem_wdata      = rdata_reg | mask;
        case (state_reg)
            S_IDLE:
            begin
                if (head_valid)
                begin
                    pop = 1'b1;
                    if (head.clear)
                    begin
                        clr_addr_next = '0;
                        kept_next     = 16'd0;
                        state_next    = S_CLEAR;
                    end
                    else
                    begin
                        mem_re     = 1'b1;
                        mem_addr   = {head.row, head.col[COL_W-1:WB]};
                        state_next = S_LOOK;
                    end
                end
            end
            S_CLEAR:
            begin
                mem_we        = 1'b1;
                mem_addr      = clr_addr_reg;
                mem_wdata     = '0;
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
                if (clr_addr_reg == ADDR_W'(MEM_DEPTH - 1))
                begin
                    init_next  = 1'b0;
                    state_next = S_IDLE;
                end
            end
            S_LOOK:
            begin
                if (rdata_reg[job_reg.col[WB-1:0]])
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    res_valid_next = 1'b1;
                    kept_next      = kept_reg + 16'd1;
                    dy_next        = -$signed({2'b00, half_reg});
                    state_next     = S_ROW;
                end
            end
            S_ROW:
            begin
                if (dy_reg > $signed({2'b00, half_reg}))
                begin
                    state_next = S_IDLE;
                end
                else if (row_ok)
                begin
                    jrow_next  = jj[ROW_W-1:0];
                    lo_next    = lo_s[COL_W-1:0];
                    hi_next    = hi_s[COL_W-1:0];
                    widx_next  = lo_s[COL_W-1:WB];
                    state_next = S_RD;
                end
                else
                begin
                    dy_next = dy_reg + (HALF_W+2)'(1);
                end
            end
            S_RD:
            begin
                mem_re     = 1'b1;
                state_next = S_WR;
            end
            S_WR:
            begin
                mem_we = 1'b1;
                if (widx_reg == hi_reg[COL_W-1:WB])
                begin
                    dy_next    = dy_reg + (HALF_W+2)'(1);
                    state_next = S_ROW;
                end
                else
                begin
                    widx_next  = widx_reg + WPR_W'(1);
                    state_next = S_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            init_reg      <= 1'b1;
            clr_addr_reg  <= '0;
            dy_reg        <= '0;
            jrow_reg      <= '0;
            lo_reg        <= '0;
            hi_reg        <= '0;
            widx_reg      <= '0;
            kept_reg      <= 16'd0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            init_reg      <= init_next;
            clr_addr_reg  <= clr_addr_next;
            dy_reg        <= dy_next;
            jrow_reg      <= jrow_next;
            lo_reg        <= lo_next;
            hi_reg        <= hi_next;
            widx_reg      <= widx_next;
            kept_reg      <= kept_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            job_reg  <= head;
            rsq_reg  <= (2*R_W)'(head.radius) * (2*R_W)'(head.radius);
            half_reg <= hsum[R_W:8];
        end
        if (res_valid_next)
        begin
            res_reg.kept_x        <= job_reg.x_pos;
            res_reg.kept_y        <= job_reg.y_pos;
            res_reg.kept_strength <= job_reg.strength;
            res_reg.kept_index    <= kept_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_addr];
        end
    end

    assign init_busy    = init_reg;
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

// ===== rtl/source_duplicate_suppressor.sv =====
// Top level of the source duplicate suppressor: configuration registers and block wiring.
`timescale 1ns / 1ps
// Sources are offered strongest first; each one whose pixel is still unseen comes out once
// on result with result_valid high for a single cycle, and the receiver cannot stall it.
// Busy is high after reset while the map memory is cleared word by word.
// A source passes through the front-end register, then the map sequencer reads its map
// word for the seen check and, for a kept source, visits each disc row and reads and writes
// back each 64-pixel map word touched, about 2R+1 rows of one or two words each.
// A clear command clears the map one map word per cycle.
// The two-entry job queue lets new transactions be taken while the sequencer works.
module source_duplicate_suppressor (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  sds_pkg::item_t                      item,
    output logic                                result_valid,
    output sds_pkg::result_t                    result,
    input  logic                                cfg_we,
    input  logic [sds_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [sds_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import sds_pkg::*;

    cfg_t  cfg_reg, cfg_next;
    logic  accept;
    logic  front_busy, push, q_full, head_valid, pop, init_busy;
    job_t  push_job, head;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_CRIT_RADIUS: cfg_next.crit_radius = cfg_data[12:0];
                REG_SAT_SCALE:   cfg_next.sat_scale   = cfg_data[23:0];
                REG_BAND_SELECT: cfg_next.band_select = cfg_data[2:0];
                REG_MAP_WIDTH:   cfg_next.map_width   = cfg_data[10:0];
                REG_MAP_HEIGHT:  cfg_next.map_height  = cfg_data[10:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.crit_radius <= 13'd768;
            cfg_reg.sat_scale   <= 24'd65536;
            cfg_reg.band_select <= 3'd0;
            cfg_reg.map_width   <= 11'd1024;
            cfg_reg.map_height  <= 11'd1024;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign busy   = init_busy || front_busy || q_full;
    assign accept = start && !busy;

    sds_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .accept (accept),
        .item   (item),
        .busy   (front_busy),
        .push   (push),
        .job    (push_job)
    );

    sds_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head),
        .full       (q_full)
    );

    sds_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .head_valid   (head_valid),
        .head         (head),
        .pop          (pop),
        .init_busy    (init_busy),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

// ===== rtl/sds_checker.sv =====
// Port-level checks of the source duplicate suppressor and their binding.
`timescale 1ns / 1ps
module sds_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  logic              result_valid,
    input  sds_pkg::result_t  result
);
    import sds_pkg::*;

    // A taken transaction occupies the front end for the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("no busy after an accepted transaction");

    // The seen check and the disc marking separate any two kept sources.
    a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("kept sources on consecutive cycles");

    // A kept source always rounds to a pixel of at least column one and row one.
    a_on_map: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ((result.kept_x[13:3] != 11'd0) && (result.kept_y[13:3] != 11'd0)))
        else $error("kept source lies off the map");

endmodule

bind source_duplicate_suppressor sds_checker u_sds_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result)
);
